### rtl/core/ovl_pkg.sv
// Shared types and constants for the ordered value list.
package ovl_pkg;

	localparam int DEPTH_DEF = 32;
	localparam int DATA_W    = 32;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_LIST   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_LS_RD,
		S_LS_OUT,
		S_RM_RD,
		S_RM_CMP,
		S_SH_RD,
		S_SH_WR,
		S_RM_FIN
	} state_t;

	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] value;
		status_t           status;
		logic              last;
	} emit_t;

endpackage

### rtl/core/ovl_mem.sv
// Entry memory: one write port, one read port, registered read data.
module ovl_mem import ovl_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/ovl_ctrl.sv
// Command sequencer: fill count, scan and shift over the entry memory.
module ovl_ctrl import ovl_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH),
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               cmd,
	input  logic signed [DATA_W-1:0] item_value,
	input  logic                     out_free,
	output emit_t                    emit,
	output logic                     mem_we,
	output logic [AW-1:0]            mem_waddr,
	output logic [DATA_W-1:0]        mem_wdata,
	output logic                     mem_re,
	output logic [AW-1:0]            mem_raddr,
	input  logic [DATA_W-1:0]        mem_rdata
);

	state_t            state_q, state_d;
	logic [AW-1:0]     idx_q, idx_d;
	logic [CW-1:0]     fill_q, fill_d;
	cmd_t              cmd_q;
	logic [DATA_W-1:0] val_q;
	logic [CW-1:0]     idx_p1;
	logic [CW-1:0]     idx_p2;
	logic              full;
	logic              at_end;

	assign idx_p1 = CW'(idx_q) + CW'(1);
	assign idx_p2 = CW'(idx_q) + CW'(2);
	assign full   = (fill_q == CW'(DEPTH));
	assign at_end = (idx_p1 == fill_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			fill_q  <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= cmd_t'(cmd);
			val_q <= item_value;
		end
	end

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		fill_d    = fill_q;
		in_ready  = 1'b0;
		emit      = '0;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = mem_rdata;
		mem_re    = 1'b0;
		mem_raddr = idx_q;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_DEC;
					idx_d   = '0;
				end
			end
			S_DEC: begin
				case (cmd_q)
					CMD_APPEND: begin
						if (out_free) begin
							emit.valid  = 1'b1;
							emit.last   = 1'b1;
							emit.status = full ? ST_FULL : ST_OK;
							if (!full) begin
								mem_we    = 1'b1;
								mem_waddr = fill_q[AW-1:0];
								mem_wdata = val_q;
								fill_d    = fill_q + CW'(1);
							end
							state_d = S_IDLE;
						end
					end
					CMD_REMOVE: begin
						if (fill_q == '0) begin
							if (out_free) begin
								emit.valid  = 1'b1;
								emit.last   = 1'b1;
								emit.status = ST_NOT_FOUND;
								state_d     = S_IDLE;
							end
						end else begin
							state_d = S_RM_RD;
						end
					end
					CMD_CLEAR: begin
						if (out_free) begin
							emit.valid  = 1'b1;
							emit.last   = 1'b1;
							emit.status = ST_OK;
							fill_d      = '0;
							state_d     = S_IDLE;
						end
					end
					default: begin
						if (fill_q == '0) begin
							if (out_free) begin
								emit.valid  = 1'b1;
								emit.last   = 1'b1;
								emit.status = ST_EMPTY;
								state_d     = S_IDLE;
							end
						end else begin
							state_d = S_LS_RD;
						end
					end
				endcase
			end
			S_LS_RD: begin
				mem_re  = 1'b1;
				state_d = S_LS_OUT;
			end
			S_LS_OUT: begin
				if (out_free) begin
					emit.valid  = 1'b1;
					emit.value  = mem_rdata;
					emit.status = ST_OK;
					emit.last   = at_end;
					if (at_end) begin
						state_d = S_IDLE;
					end else begin
						idx_d   = idx_q + AW'(1);
						state_d = S_LS_RD;
					end
				end
			end
			S_RM_RD: begin
				mem_re  = 1'b1;
				state_d = S_RM_CMP;
			end
			S_RM_CMP: begin
				if (mem_rdata == val_q) begin
					state_d = at_end ? S_RM_FIN : S_SH_RD;
				end else if (at_end) begin
					if (out_free) begin
						emit.valid  = 1'b1;
						emit.last   = 1'b1;
						emit.status = ST_NOT_FOUND;
						state_d     = S_IDLE;
					end
				end else begin
					idx_d   = idx_q + AW'(1);
					state_d = S_RM_RD;
				end
			end
			S_SH_RD: begin
				mem_re    = 1'b1;
				mem_raddr = idx_q + AW'(1);
				state_d   = S_SH_WR;
			end
			S_SH_WR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = mem_rdata;
				idx_d     = idx_q + AW'(1);
				state_d   = (idx_p2 == fill_q) ? S_RM_FIN : S_SH_RD;
			end
			S_RM_FIN: begin
				if (out_free) begin
					emit.valid  = 1'b1;
					emit.last   = 1'b1;
					emit.status = ST_OK;
					fill_d      = fill_q - CW'(1);
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### rtl/core/ordered_value_list.sv
// Ordered value list: append, remove first match, clear, list all.
// Append, clear, empty list, remove on empty: emitted in decode, registered at the output.
// List: a decode state, then per entry a memory read state and an output load state.
// Remove: decode, read/compare per entry scanned, read/write per shift, finish on a match.
// The single read port sets these read-then-use steps; a new item is taken only in idle.
// Reset clears sequencer state, fill count and output valid; entries are not cleared.
module ordered_value_list import ovl_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               cmd,
	input  logic signed [DATA_W-1:0] item_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] out_value,
	output logic [1:0]               status,
	output logic                     last
);

	localparam int AW = $clog2(DEPTH);

	emit_t             emit;
	logic              out_free;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;
	logic              out_valid_q;
	logic [DATA_W-1:0] out_value_q;
	status_t           status_q;
	logic              last_q;

	assign out_free = !out_valid_q || out_ready;

	ovl_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.item_value(item_value),
		.out_free  (out_free),
		.emit      (emit),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	ovl_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit.valid) begin
			out_value_q <= emit.value;
			status_q    <= emit.status;
			last_q      <= emit.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

### rtl/core/ovl_chk.sv
// Port-level checks for the ordered value list, bound to the top level.
module ovl_chk import ovl_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_ready,
	input logic [1:0]               cmd,
	input logic signed [DATA_W-1:0] item_value,
	input logic                     out_valid,
	input logic                     out_ready,
	input logic signed [DATA_W-1:0] out_value,
	input logic [1:0]               status,
	input logic                     last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value)
			&& $stable(status) && $stable(last))
		else $error("result changed while stalled");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL || status == ST_NOT_FOUND
			|| status == ST_EMPTY) |-> last)
		else $error("error status not marked last");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> out_value == '0)
		else $error("nonzero value on status result");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while previous one in work");

endmodule

bind ordered_value_list ovl_chk u_ovl_chk (.*);

### sim/tb.sv
// Testbench for ordered_value_list: directed table, then random mix against a predictor.
module tb;
	import ovl_pkg::*;

	localparam int DEPTH      = DEPTH_DEF;
	localparam int RAND_ITEMS = 400;
	localparam int CALM_ITEMS = 60;

	typedef struct {
		logic [31:0] value;
		status_t     status;
		logic        last;
	} result_t;

	typedef struct {
		cmd_t        c;
		logic [31:0] v;
		bit          typed;
		status_t     st;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         cmd;
	logic signed [31:0] item_value;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] out_value;
	logic [1:0]         status;
	logic               last;

	logic [31:0] stored_values[$];
	result_t     op_results[$];
	result_t     pending_results[$];
	result_t     want;
	int          errors = 0;
	int          idle_pct = 0;
	bit          calm = 1'b0;

	dir_row_t directed_rows [0:22] = '{
		'{CMD_LIST,   32'h0000_0000, 1'b1, ST_EMPTY},
		'{CMD_REMOVE, 32'h0000_0000, 1'b1, ST_NOT_FOUND},
		'{CMD_CLEAR,  32'h0000_0000, 1'b1, ST_OK},
		'{CMD_APPEND, 32'h7FFF_FFFF, 1'b1, ST_OK},
		'{CMD_APPEND, 32'h8000_0000, 1'b1, ST_OK},
		'{CMD_APPEND, 32'h0000_0000, 1'b1, ST_OK},
		'{CMD_APPEND, 32'hFFFF_FFFF, 1'b1, ST_OK},
		'{CMD_APPEND, 32'h8000_0000, 1'b1, ST_OK},
		'{CMD_APPEND, 32'h5555_5555, 1'b1, ST_OK},
		'{CMD_APPEND, 32'hAAAA_AAAA, 1'b1, ST_OK},
		'{CMD_LIST,   32'h0000_0000, 1'b0, ST_OK},
		'{CMD_REMOVE, 32'h8000_0000, 1'b1, ST_OK},
		'{CMD_LIST,   32'h0000_0000, 1'b0, ST_OK},
		'{CMD_REMOVE, 32'h7FFF_FFFE, 1'b1, ST_NOT_FOUND},
		'{CMD_REMOVE, 32'hAAAA_AAAA, 1'b1, ST_OK},
		'{CMD_REMOVE, 32'h7FFF_FFFF, 1'b1, ST_OK},
		'{CMD_LIST,   32'hDEAD_BEEF, 1'b0, ST_OK},
		'{CMD_CLEAR,  32'h1234_5678, 1'b1, ST_OK},
		'{CMD_LIST,   32'hFFFF_FFFF, 1'b1, ST_EMPTY},
		'{CMD_APPEND, 32'h0000_0001, 1'b1, ST_OK},
		'{CMD_REMOVE, 32'h0000_0001, 1'b1, ST_OK},
		'{CMD_LIST,   32'h0000_0000, 1'b1, ST_EMPTY},
		'{CMD_REMOVE, 32'hFFFF_FFFF, 1'b1, ST_NOT_FOUND}
	};

	ordered_value_list #(.DEPTH(DEPTH)) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.item_value (item_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_value  (out_value),
		.status     (status),
		.last       (last)
	);

	always #10 clk = ~clk;

	function automatic void predict_list_op(input cmd_t c, input logic [31:0] v);
		int hit;
		hit = -1;
		op_results.delete();
		case (c)
			CMD_APPEND: begin
				if (stored_values.size() >= DEPTH) begin
					op_results.push_back(result_t'{32'd0, ST_FULL, 1'b1});
				end else begin
					stored_values.push_back(v);
					op_results.push_back(result_t'{32'd0, ST_OK, 1'b1});
				end
			end
			CMD_REMOVE: begin
				foreach (stored_values[k])
					if (hit < 0 && stored_values[k] == v)
						hit = k;
				if (hit < 0) begin
					op_results.push_back(result_t'{32'd0, ST_NOT_FOUND, 1'b1});
				end else begin
					stored_values.delete(hit);
					op_results.push_back(result_t'{32'd0, ST_OK, 1'b1});
				end
			end
			CMD_CLEAR: begin
				stored_values.delete();
				op_results.push_back(result_t'{32'd0, ST_OK, 1'b1});
			end
			default: begin
				if (stored_values.size() == 0)
					op_results.push_back(result_t'{32'd0, ST_EMPTY, 1'b1});
				else
					foreach (stored_values[k])
						op_results.push_back(result_t'{stored_values[k], ST_OK,
							k == stored_values.size() - 1});
			end
		endcase
	endfunction

	// small pool gives duplicates so first-match removal is exercised
	function automatic logic [31:0] pick_value();
		logic [31:0] pool [0:7];
		pool = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd7, 32'h8000_0000, 32'h7FFF_FFFF,
			32'd100, 32'hFFFF_FF9C};
		if ($urandom_range(0, 1) == 0)
			return pool[$urandom_range(0, 7)];
		return $urandom();
	endfunction

	function automatic logic [31:0] pick_remove_value();
		if (stored_values.size() != 0 && $urandom_range(0, 99) < 75)
			return stored_values[$urandom_range(0, stored_values.size() - 1)];
		return pick_value();
	endfunction

	task automatic send_item(input cmd_t c, input logic [31:0] v, input bit typed,
		input status_t st);
		if (!calm && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		cmd        <= c;
		item_value <= v;
		in_valid   <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_list_op(c, v);
		if (typed)
			pending_results.push_back(result_t'{32'd0, st, 1'b1});
		else
			foreach (op_results[k]) pending_results.push_back(op_results[k]);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		out_ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 40)) @(posedge clk);
			if (!calm && $urandom_range(0, 9) < 6) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: out_value %0d status %0d last %0b",
					out_value, status, last);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (out_value !== want.value) begin
					$error("out_value: expected %0d, got %0d", $signed(want.value), out_value);
					errors++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					errors++;
				end
				if (last !== want.last) begin
					$error("last: expected %0b, got %0b", want.last, last);
					errors++;
				end
			end
		end
	end

	initial begin
		int sent;
		int phase;
		int n;
		int r;
		sent  = 0;
		phase = 0;
		in_valid   <= 1'b0;
		cmd        <= CMD_APPEND;
		item_value <= '0;
		wait (arst_n);
		@(posedge clk);

		foreach (directed_rows[i])
			send_item(directed_rows[i].c, directed_rows[i].v, directed_rows[i].typed,
				directed_rows[i].st);

		while (sent < RAND_ITEMS) begin
			calm = (sent >= RAND_ITEMS - CALM_ITEMS);
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 15;
				default: idle_pct = 40;
			endcase
			if ($urandom_range(0, 3) == 0) begin
				// fill to capacity, overflow a few times, then read back
				n = DEPTH - stored_values.size() + $urandom_range(1, 3);
				repeat (n) send_item(CMD_APPEND, pick_value(), 1'b0, ST_OK);
				send_item(CMD_LIST, $urandom(), 1'b0, ST_OK);
				sent += n + 1;
			end else begin
				n = $urandom_range(15, 40);
				repeat (n) begin
					r = $urandom_range(0, 99);
					if (r < 45)
						send_item(CMD_APPEND, pick_value(), 1'b0, ST_OK);
					else if (r < 80)
						send_item(CMD_REMOVE, pick_remove_value(), 1'b0, ST_OK);
					else if (r < 93)
						send_item(CMD_LIST, $urandom(), 1'b0, ST_OK);
					else
						send_item(CMD_CLEAR, $urandom(), 1'b0, ST_OK);
				end
				sent += n;
			end
			if (phase == 0 || (!calm && $urandom_range(0, 2) == 0))
				wait_drained();
			phase++;
		end

		wait_drained();
		repeat (150) @(posedge clk);
		if (errors == 0)
			$display("ordered_value_list: match");
		else
			$display("ordered_value_list: mismatch");
		$finish;
	end

	initial begin
		#40000000;
		$display("ordered_value_list: mismatch");
		$finish;
	end

endmodule

### files.f
rtl/core/ovl_pkg.sv
rtl/core/ovl_mem.sv
rtl/core/ovl_ctrl.sv
rtl/core/ordered_value_list.sv
rtl/core/ovl_chk.sv
sim/tb.sv
